/* design/ecpt_pkg.sv */
// Shared types and constants for the entity component presence table.
// Field widths, operation and status codes, controller state and the
// command/status structs between controller and datapath. No dependencies.
package ecpt_pkg;

   // Default sizing handed to the top level
   localparam int MAX_ENTITIES_DEF = 1024;
   localparam int TYPE_COUNT_DEF   = 32;

   // Fixed field widths
   localparam int KIND_W   = 3;
   localparam int ENT_W    = 10;
   localparam int CTYPE_W  = 5;
   localparam int MASK_W   = 32;
   localparam int STATUS_W = 2;

   // Stream word widths, padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_CREATE  = 3'd0,
      KIND_DESTROY = 3'd1,
      KIND_ADD     = 3'd2,
      KIND_REMOVE  = 3'd3,
      KIND_HAS     = 3'd4,
      KIND_QSTART  = 3'd5,
      KIND_QNEXT   = 3'd6,
      KIND_QRESET  = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_INVALID   = 2'd2,
      STAT_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_CHK
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_we;        // write zero at clear pointer, advance it
      logic accept;        // capture request word, read its entity
      logic op_fire;       // commit the captured operation, load result
      logic scan_step;     // read at scan position, advance it
      logic scan_hit;      // load found-entity result
      logic scan_exhaust;  // load query-exhausted result
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_qnext;    // offered request is a query next
      logic clear_last;  // clear pointer at the last entry
      logic scan_end;    // scan position reached next free id
      logic scan_zero;   // scan position is the invalid id 0
      logic match;       // scanned mask holds all required bits
      logic slot_free;   // result register can take a word
   } dp_status_type;

endpackage

/* design/ecpt_ctrl.sv */
// Controller state machine for the entity component presence table.
// Sequences clearing, operation execution and query scans; uses ecpt_pkg.
module ecpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ecpt_pkg::dp_status_type sts,
   output ecpt_pkg::ctrl_cmd_type  cmd
);

   ecpt_pkg::ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecpt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ecpt_pkg::ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (sts.clear_last) begin
               state_in = ecpt_pkg::ST_IDLE;
            end
         end
         ecpt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.in_qnext ? ecpt_pkg::ST_SCAN_RD : ecpt_pkg::ST_EXEC;
            end
         end
         ecpt_pkg::ST_EXEC: begin
            if (sts.slot_free) begin
               cmd.op_fire = 1'b1;
               state_in    = ecpt_pkg::ST_IDLE;
            end
         end
         ecpt_pkg::ST_SCAN_RD: begin
            if (sts.scan_end) begin
               if (sts.slot_free) begin
                  cmd.scan_exhaust = 1'b1;
                  state_in         = ecpt_pkg::ST_IDLE;
               end
            end else begin
               // id 0 is skipped without a check
               cmd.scan_step = 1'b1;
               if (!sts.scan_zero) begin
                  state_in = ecpt_pkg::ST_SCAN_CHK;
               end
            end
         end
         ecpt_pkg::ST_SCAN_CHK: begin
            if (sts.match) begin
               if (sts.slot_free) begin
                  cmd.scan_hit = 1'b1;
                  state_in     = ecpt_pkg::ST_IDLE;
               end
            end else begin
               state_in = ecpt_pkg::ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ecpt_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

/* design/ecpt_datapath.sv */
// Datapath for the entity component presence table: mask memory, allocator,
// query registers and the result register. Driven by ecpt_ctrl; uses ecpt_pkg.
module ecpt_datapath #(
   parameter int MAX_ENTITIES = ecpt_pkg::MAX_ENTITIES_DEF,
   parameter int TYPE_COUNT   = ecpt_pkg::TYPE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ecpt_pkg::ctrl_cmd_type            cmd,
   output ecpt_pkg::dp_status_type           sts,
   input  logic [ecpt_pkg::KIND_W-1:0]       req_tuser,
   input  logic [ecpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [ecpt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int AW = $clog2(MAX_ENTITIES);      // memory index
   localparam int CW = $clog2(MAX_ENTITIES + 1);  // id counters, hold MAX
   localparam int XW = 17;                        // room for MAX up to 65536

   // Mask memory, one word per entity
   logic [TYPE_COUNT-1:0] masks_mem [MAX_ENTITIES];
   logic [TYPE_COUNT-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [TYPE_COUNT-1:0] mem_wd;

   // Control registers
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]  nfid_ff, nfid_in;
   logic [CW-1:0]  sp_ff, sp_in;
   logic [CW-1:0]  scan_id_ff, scan_id_in;
   logic [ecpt_pkg::MASK_W-1:0] qreq_ff, qreq_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Captured request word
   ecpt_pkg::kind_type            op_kind_ff;
   logic [ecpt_pkg::ENT_W-1:0]    op_ent_ff;
   logic [ecpt_pkg::CTYPE_W-1:0]  op_type_ff;
   logic [ecpt_pkg::MASK_W-1:0]   op_mask_ff;

   // Result register
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [ecpt_pkg::ENT_W-1:0]       rsp_ent_ff, rsp_ent_in;
   ecpt_pkg::status_type             rsp_stat_ff, rsp_stat_in;

   logic [ecpt_pkg::ENT_W-1:0] in_ent;
   logic [XW-1:0]              in_ent_x, op_ent_x;
   logic                       ent_ok, type_ok;
   logic [ecpt_pkg::MASK_W-1:0] rd_full;
   logic [TYPE_COUNT-1:0]       type_bit;
   logic                        rsp_load;

   assign in_ent   = req_tdata[9:0];
   assign in_ent_x = XW'(in_ent);
   assign op_ent_x = XW'(op_ent_ff);
   assign ent_ok   = (op_ent_ff != '0) && (op_ent_x < XW'(MAX_ENTITIES));
   assign type_ok  = 6'(op_type_ff) < 6'(TYPE_COUNT);
   assign rd_full  = ecpt_pkg::MASK_W'(rd_data_ff);
   assign type_bit = TYPE_COUNT'(1) << op_type_ff;

   // Status toward the controller
   assign sts.in_qnext   = (ecpt_pkg::kind_type'(req_tuser) == ecpt_pkg::KIND_QNEXT);
   assign sts.clear_last = (clr_cnt_ff == AW'(MAX_ENTITIES - 1));
   assign sts.scan_end   = (sp_ff >= nfid_ff);
   assign sts.scan_zero  = (sp_ff == '0);
   assign sts.match      = ((qreq_ff & ~rd_full) == '0);
   assign sts.slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_load = cmd.op_fire || cmd.scan_hit || cmd.scan_exhaust;

   // Memory port selection
   assign mem_re = cmd.accept || cmd.scan_step;
   assign mem_ra = cmd.accept ? in_ent_x[AW-1:0] : sp_ff[AW-1:0];

   // Operation execution and register updates
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      nfid_in      = nfid_ff;
      sp_in        = sp_ff;
      scan_id_in   = scan_id_ff;
      qreq_in      = qreq_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_stat_in  = rsp_stat_ff;
      mem_we       = 1'b0;
      mem_wa       = op_ent_x[AW-1:0];
      mem_wd       = '0;

      if (cmd.clr_we) begin
         mem_we     = 1'b1;
         mem_wa     = clr_cnt_ff;
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end

      if (cmd.scan_step) begin
         scan_id_in = sp_ff;
         sp_in      = sp_ff + CW'(1);
      end

      if (cmd.scan_hit) begin
         rsp_ok_in   = 1'b1;
         rsp_ent_in  = ecpt_pkg::ENT_W'(scan_id_ff);
         rsp_stat_in = ecpt_pkg::STAT_OK;
      end

      if (cmd.scan_exhaust) begin
         rsp_ok_in   = 1'b0;
         rsp_ent_in  = '0;
         rsp_stat_in = ecpt_pkg::STAT_EXHAUSTED;
      end

      if (cmd.op_fire) begin
         rsp_ok_in   = 1'b1;
         rsp_ent_in  = '0;
         rsp_stat_in = ecpt_pkg::STAT_OK;
         case (op_kind_ff)
            ecpt_pkg::KIND_CREATE: begin
               if (nfid_ff < CW'(MAX_ENTITIES)) begin
                  rsp_ent_in = ecpt_pkg::ENT_W'(nfid_ff);
                  nfid_in    = nfid_ff + CW'(1);
               end else begin
                  rsp_ok_in   = 1'b0;
                  rsp_stat_in = ecpt_pkg::STAT_FULL;
               end
            end
            ecpt_pkg::KIND_DESTROY: begin
               if (ent_ok) begin
                  mem_we = 1'b1;
                  mem_wd = '0;
               end else begin
                  rsp_ok_in   = 1'b0;
                  rsp_stat_in = ecpt_pkg::STAT_INVALID;
               end
            end
            ecpt_pkg::KIND_ADD, ecpt_pkg::KIND_REMOVE: begin
               if (ent_ok && type_ok) begin
                  mem_we = 1'b1;
                  mem_wd = (op_kind_ff == ecpt_pkg::KIND_ADD) ? (rd_data_ff | type_bit)
                                                              : (rd_data_ff & ~type_bit);
               end else begin
                  rsp_ok_in   = 1'b0;
                  rsp_stat_in = ecpt_pkg::STAT_INVALID;
               end
            end
            ecpt_pkg::KIND_HAS: begin
               if (ent_ok) begin
                  rsp_ok_in = ((op_mask_ff & ~rd_full) == '0);
               end else begin
                  rsp_ok_in   = 1'b0;
                  rsp_stat_in = ecpt_pkg::STAT_INVALID;
               end
            end
            ecpt_pkg::KIND_QSTART: begin
               qreq_in = op_mask_ff;
               sp_in   = '0;
            end
            ecpt_pkg::KIND_QRESET: begin
               sp_in = '0;
            end
            default: begin
               // query next runs through the scan path
            end
         endcase
      end
   end

   // Result valid: load wins, a taken word clears it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         nfid_ff      <= CW'(1);
         sp_ff        <= '0;
         qreq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         nfid_ff      <= nfid_in;
         sp_ff        <= sp_in;
         qreq_ff      <= qreq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_id_ff  <= scan_id_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_ent_ff  <= rsp_ent_in;
      rsp_stat_ff <= rsp_stat_in;
      if (cmd.accept) begin
         op_kind_ff <= ecpt_pkg::kind_type'(req_tuser);
         op_ent_ff  <= in_ent;
         op_type_ff <= req_tdata[14:10];
         op_mask_ff <= req_tdata[46:15];
      end
   end

   // Mask memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         masks_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= masks_mem[mem_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_stat_ff, rsp_ent_ff, rsp_ok_ff};

endmodule

/* design/entity_component_presence_table_unit.sv */
// Entity component presence table, top level. A taken request word is captured
// and its entity's mask read; the operation commits and loads the result word
// once the result register is free. Query next reads, then checks, each id,
// paced by the mask memory's registered read; id 0 is skipped without a check.
// One request in flight; the next is taken while a result waits. Reset:
// synchronous; a clearing pass over all MAX_ENTITIES entries zeroes the mask memory, during which no word is taken.
module entity_component_presence_table_unit #(
   parameter int MAX_ENTITIES = ecpt_pkg::MAX_ENTITIES_DEF,
   parameter int TYPE_COUNT   = ecpt_pkg::TYPE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tuser: kind [2:0]
   input  logic [ecpt_pkg::KIND_W-1:0]     req_tuser,
   // req_tdata: entity [9:0], component_type [14:10], mask [46:15], zero pad
   input  logic [ecpt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: success [0], entity_out [10:1], status [12:11], zero pad
   output logic [ecpt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ecpt_pkg::ctrl_cmd_type  cmd;
   ecpt_pkg::dp_status_type sts;

   ecpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ecpt_datapath #(
      .MAX_ENTITIES (MAX_ENTITIES),
      .TYPE_COUNT   (TYPE_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // No request taken while the mask memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_we |-> !req_tready)
      else $error("request taken during clearing pass");

   // One request at a time: a taken word blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");

   // A result is loaded only into a free slot, from one source
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op_fire || cmd.scan_hit || cmd.scan_exhaust) |->
         (sts.slot_free && $onehot({cmd.op_fire, cmd.scan_hit, cmd.scan_exhaust})))
      else $error("result loaded over a pending word");

   // Scan never advances past the next free id
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !sts.scan_end)
      else $error("scan stepped past allocated ids");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for entity_component_presence_table_unit.
// Depends on ecpt_pkg and the top level in design/; a ledger class predicts
// every reply word from its own copy of the presence table.

// Fields of one reply word
typedef struct packed {
   logic                       success;
   logic [ecpt_pkg::ENT_W-1:0] entity_out;
   ecpt_pkg::status_type       status;
} reply_fields_type;

// Mirror of the presence table and the replies still owed by the block
class presence_ledger;
   localparam int MAXE  = ecpt_pkg::MAX_ENTITIES_DEF;
   localparam int TYPES = ecpt_pkg::TYPE_COUNT_DEF;

   logic [ecpt_pkg::MASK_W-1:0] masks [MAXE];
   int unsigned                 next_id;
   int unsigned                 scan_pos;
   logic [ecpt_pkg::MASK_W-1:0] required;
   reply_fields_type            awaited [$];
   int unsigned                 noted;
   int unsigned                 replies;
   int unsigned                 mismatches;
   int unsigned                 kind_seen [8];
   int unsigned                 status_seen [4];

   function new();
      foreach (masks[i]) masks[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      next_id    = 1;
      scan_pos   = 0;
      required   = '0;
      noted      = 0;
      replies    = 0;
      mismatches = 0;
   endfunction

   // Apply one operation to the mirrored table and return its reply
   function reply_fields_type execute_op(ecpt_pkg::kind_type k, int unsigned ent,
                                         int unsigned ctype,
                                         logic [ecpt_pkg::MASK_W-1:0] m);
      reply_fields_type r;
      bit               ent_ok;
      bit               found;
      int unsigned      id;
      r.success    = 1'b0;
      r.entity_out = '0;
      r.status     = ecpt_pkg::STAT_OK;
      ent_ok       = (ent != 0) && (ent < MAXE);
      found        = 1'b0;
      case (k)
         ecpt_pkg::KIND_CREATE: begin
            if (next_id >= MAXE)
               r.status = ecpt_pkg::STAT_FULL;
            else begin
               r.success    = 1'b1;
               r.entity_out = ecpt_pkg::ENT_W'(next_id);
               next_id++;
            end
         end
         ecpt_pkg::KIND_DESTROY: begin
            if (!ent_ok)
               r.status = ecpt_pkg::STAT_INVALID;
            else begin
               masks[ent] = '0;
               r.success  = 1'b1;
            end
         end
         ecpt_pkg::KIND_ADD, ecpt_pkg::KIND_REMOVE: begin
            if (!ent_ok || ctype >= TYPES)
               r.status = ecpt_pkg::STAT_INVALID;
            else begin
               if (k == ecpt_pkg::KIND_ADD)
                  masks[ent] |= ecpt_pkg::MASK_W'(1) << ctype;
               else
                  masks[ent] &= ~(ecpt_pkg::MASK_W'(1) << ctype);
               r.success = 1'b1;
            end
         end
         ecpt_pkg::KIND_HAS: begin
            if (!ent_ok)
               r.status = ecpt_pkg::STAT_INVALID;
            else
               r.success = ((m & ~masks[ent]) == '0);
         end
         ecpt_pkg::KIND_QSTART: begin
            required  = m;
            scan_pos  = 0;
            r.success = 1'b1;
         end
         ecpt_pkg::KIND_QNEXT: begin
            // walk allocated ids upward; id 0 is skipped
            r.status = ecpt_pkg::STAT_EXHAUSTED;
            while (!found && scan_pos < next_id) begin
               id = scan_pos;
               scan_pos++;
               if (id != 0 && id < MAXE && (required & ~masks[id]) == '0) begin
                  found        = 1'b1;
                  r.success    = 1'b1;
                  r.entity_out = ecpt_pkg::ENT_W'(id);
                  r.status     = ecpt_pkg::STAT_OK;
               end
            end
         end
         default: begin
            scan_pos  = 0;
            r.success = 1'b1;
         end
      endcase
      return r;
   endfunction

   // Called when a request word is taken by the block
   function void note_request(ecpt_pkg::kind_type k, logic [ecpt_pkg::ENT_W-1:0] ent,
                              logic [ecpt_pkg::CTYPE_W-1:0] ctype,
                              logic [ecpt_pkg::MASK_W-1:0] m);
      reply_fields_type r;
      r = execute_op(k, ent, ctype, m);
      awaited.push_back(r);
      noted++;
      kind_seen[k]++;
      status_seen[r.status]++;
   endfunction

   task report_mismatch(string what);
      $display("mismatch on reply %0d: %s", replies, what);
      mismatches++;
   endtask

   // rsp_tdata: success [0], entity_out [10:1], status [12:11], zero pad above
   task check_reply(logic [ecpt_pkg::RSP_DATA_W-1:0] word);
      reply_fields_type want;
      replies++;
      if (awaited.size() == 0)
         report_mismatch($sformatf("word %h with no request outstanding", word));
      else begin
         want = awaited.pop_front();
         if (word[0] !== want.success)
            report_mismatch($sformatf("success %b, expected %b", word[0], want.success));
         if (word[10:1] !== want.entity_out)
            report_mismatch($sformatf("entity_out %0d, expected %0d",
                                      word[10:1], want.entity_out));
         if (word[12:11] !== want.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      word[12:11], want.status.name()));
         if (word[ecpt_pkg::RSP_DATA_W-1:13] !== '0)
            report_mismatch($sformatf("pad bits %b not zero",
                                      word[ecpt_pkg::RSP_DATA_W-1:13]));
      end
   endtask
endclass

module testbench;
   localparam int          HALF_PERIOD = 2;
   localparam int          ITEMS       = 1400;
   localparam int          FILL_AFTER  = 1000;
   localparam int          LONG_HOLD   = 400;
   localparam int          TAIL_CYCLES = 20;
   // the slowest correct run spends most of its time in query scans
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [ecpt_pkg::KIND_W-1:0]       req_tuser  = '0;
   logic [ecpt_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [ecpt_pkg::RSP_DATA_W-1:0]   rsp_tdata;

   presence_ledger book;
   bit             sender_calm = 1'b0;
   int unsigned    cycle_count = 0;

   entity_component_presence_table_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, book.awaited.size());
         $display("status: fail");
         $finish;
      end
   end

   // Mostly ids already handed out, now and then any id or the invalid id 0
   function automatic logic [ecpt_pkg::ENT_W-1:0] pick_entity();
      int unsigned roll;
      roll = $urandom_range(0, 29);
      if (roll == 0)
         return '0;
      if (roll < 5 || book.next_id < 2)
         return ecpt_pkg::ENT_W'($urandom_range(1, ecpt_pkg::MAX_ENTITIES_DEF - 1));
      return ecpt_pkg::ENT_W'($urandom_range(1, book.next_id - 1));
   endfunction

   // Offer one request word after a random gap and wait until it is taken
   // req_tdata: entity [9:0], component_type [14:10], mask [46:15], zero pad
   task automatic send_word(ecpt_pkg::kind_type k, logic [ecpt_pkg::ENT_W-1:0] ent,
                            logic [ecpt_pkg::CTYPE_W-1:0] ctype,
                            logic [ecpt_pkg::MASK_W-1:0] m);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {1'b0, m, ctype, ent};
      do @(posedge clock); while (req_tready !== 1'b1);
      book.note_request(k, ent, ctype, m);
   endtask

   // Stop offering until every owed reply has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.awaited.size() != 0) @(posedge clock);
   endtask

   // Reply side: random stalls, calm stretches, and two long hold-offs
   initial begin : reply_sink
      int unsigned stall;
      bit          calm;
      calm = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (book.replies == 250 || book.replies == 900)
            stall = LONG_HOLD;
         else
            stall = calm ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 39) == 0)
            calm = !calm;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         book.check_reply(rsp_tdata);
      end
   end

   initial begin : stimulus
      logic [ecpt_pkg::MASK_W-1:0] m;
      logic [ecpt_pkg::ENT_W-1:0]  ent;
      int unsigned                 burst;
      int unsigned                 pick;
      int unsigned                 round;
      book  = new();
      round = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: invalid id 0 on every checked kind, empty scan, type extremes
      send_word(ecpt_pkg::KIND_HAS,     '0,      5'd0,  32'hFFFF_FFFF);
      send_word(ecpt_pkg::KIND_DESTROY, '0,      5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_ADD,     '0,      5'd31, 32'h0);
      send_word(ecpt_pkg::KIND_REMOVE,  '0,      5'd31, 32'h0);
      send_word(ecpt_pkg::KIND_QNEXT,   10'h3FF, 5'd31, 32'hFFFF_FFFF);
      send_word(ecpt_pkg::KIND_CREATE,  10'h3FF, 5'd31, 32'hFFFF_FFFF);
      send_word(ecpt_pkg::KIND_CREATE,  '0,      5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_ADD,     10'd1,   5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_ADD,     10'd1,   5'd31, 32'h0);
      // id in range but never handed out can still be changed and tested
      send_word(ecpt_pkg::KIND_ADD,     10'h3FF, 5'd5,  32'h0);
      send_word(ecpt_pkg::KIND_HAS,     10'd1,   5'd0,  32'h8000_0001);
      send_word(ecpt_pkg::KIND_HAS,     10'd1,   5'd0,  32'hFFFF_FFFF);
      send_word(ecpt_pkg::KIND_HAS,     10'd2,   5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_HAS,     10'h3FF, 5'd0,  32'h0000_0020);
      send_word(ecpt_pkg::KIND_REMOVE,  10'd1,   5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_QSTART,  '0,      5'd0,  32'h8000_0000);
      send_word(ecpt_pkg::KIND_QNEXT,   '0,      5'd0,  32'h0);
      // unallocated id 1023 must not be returned
      send_word(ecpt_pkg::KIND_QNEXT,   '0,      5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_QRESET,  10'h3FF, 5'd31, 32'hFFFF_FFFF);
      send_word(ecpt_pkg::KIND_QSTART,  '0,      5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_QNEXT,   '0,      5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_QNEXT,   '0,      5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_DESTROY, 10'd1,   5'd0,  32'h0);
      send_word(ecpt_pkg::KIND_QRESET,  '0,      5'd0,  32'h0);
      // destroyed entity stays allocated and matches an empty required mask
      send_word(ecpt_pkg::KIND_QNEXT,   '0,      5'd0,  32'h0);
      wait_drained();

      // Random rounds: create burst, table edits, then a query walk
      while (book.noted < ITEMS) begin
         round++;
         if (book.next_id >= ecpt_pkg::MAX_ENTITIES_DEF)
            burst = $urandom_range(1, 3);
         else if (book.noted >= FILL_AFTER)
            burst = ecpt_pkg::MAX_ENTITIES_DEF - book.next_id + 3;
         else
            burst = $urandom_range(15, 60);
         repeat (burst)
            send_word(ecpt_pkg::KIND_CREATE, ecpt_pkg::ENT_W'($urandom),
                      ecpt_pkg::CTYPE_W'($urandom), $urandom);

         repeat ($urandom_range(5, 20)) begin
            ent  = pick_entity();
            pick = $urandom_range(0, 99);
            if (pick < 10)
               send_word(ecpt_pkg::KIND_DESTROY, ent, ecpt_pkg::CTYPE_W'($urandom),
                         $urandom);
            else if (pick < 45)
               send_word(ecpt_pkg::KIND_ADD, ent, ecpt_pkg::CTYPE_W'($urandom),
                         $urandom);
            else if (pick < 65)
               send_word(ecpt_pkg::KIND_REMOVE, ent, ecpt_pkg::CTYPE_W'($urandom),
                         $urandom);
            else begin
               // required bits drawn around the entity's current mask
               m = book.masks[ent];
               case ($urandom_range(0, 5))
                  0: m = '0;
                  1: m = m & $urandom;
                  2: m = m;
                  3: m = m | (ecpt_pkg::MASK_W'(1) << $urandom_range(0, 31));
                  4: m = $urandom;
                  default: m = '1;
               endcase
               send_word(ecpt_pkg::KIND_HAS, ent, ecpt_pkg::CTYPE_W'($urandom), m);
            end
         end

         ent = pick_entity();
         case ($urandom_range(0, 4))
            0: m = '0;
            1: m = ecpt_pkg::MASK_W'(1) << $urandom_range(0, 31);
            2: m = book.masks[ent] & $urandom;
            3: m = book.masks[ent];
            default: m = $urandom;
         endcase
         // now and then keep scanning with the previous query
         if ($urandom_range(0, 7) != 0)
            send_word(ecpt_pkg::KIND_QSTART, ecpt_pkg::ENT_W'($urandom),
                      ecpt_pkg::CTYPE_W'($urandom), m);
         repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               send_word(ecpt_pkg::KIND_QRESET, ecpt_pkg::ENT_W'($urandom),
                         ecpt_pkg::CTYPE_W'($urandom), $urandom);
            else if (pick == 1)
               send_word(ecpt_pkg::KIND_ADD, pick_entity(),
                         ecpt_pkg::CTYPE_W'($urandom), $urandom);
            else
               send_word(ecpt_pkg::KIND_QNEXT, ecpt_pkg::ENT_W'($urandom),
                         ecpt_pkg::CTYPE_W'($urandom), $urandom);
         end

         if (round % 4 == 0)
            wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d request words: create %0d, destroy %0d, add %0d,",
               book.noted, book.kind_seen[ecpt_pkg::KIND_CREATE],
               book.kind_seen[ecpt_pkg::KIND_DESTROY], book.kind_seen[ecpt_pkg::KIND_ADD]);
      $display("remove %0d, has %0d, query start %0d, next %0d, rewind %0d;",
               book.kind_seen[ecpt_pkg::KIND_REMOVE], book.kind_seen[ecpt_pkg::KIND_HAS],
               book.kind_seen[ecpt_pkg::KIND_QSTART], book.kind_seen[ecpt_pkg::KIND_QNEXT],
               book.kind_seen[ecpt_pkg::KIND_QRESET]);
      $display("replies ok %0d, full %0d, invalid %0d, exhausted %0d",
               book.status_seen[ecpt_pkg::STAT_OK], book.status_seen[ecpt_pkg::STAT_FULL],
               book.status_seen[ecpt_pkg::STAT_INVALID],
               book.status_seen[ecpt_pkg::STAT_EXHAUSTED]);
      if (book.mismatches == 0 && book.awaited.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

/* entity_component_presence_table_unit.f */
design/ecpt_pkg.sv
design/ecpt_ctrl.sv
design/ecpt_datapath.sv
design/entity_component_presence_table_unit.sv
sim/testbench.sv
